// File: hdl/rmbp_pkg.sv
// Shared types and constants of the radial missing-bin pad encoder.
// Holds the state enums, the descriptor passed from front to back, and the run table.
// No dependencies.
package rmbp_pkg;

    // Restoring divider: one quotient bit per cycle over a 12-bit numerator
    localparam int DIV_STEPS = 12;
    localparam int CNT_W     = 4;

    // Division by 30 as a reciprocal product: exact for numerators below 4681
    localparam logic [11:0] RUN_RECIP = 12'd2185;
    localparam int          RUN_SHIFT = 16;

    // Descriptor queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QFILL_W     = 2;

    localparam logic [15:0] RUN_WORD   = 16'hF0F0;
    localparam logic [4:0]  RUN_BINS   = 5'd30;
    localparam logic [5:0]  MAX_WORDS  = 6'd35;
    localparam logic [4:0]  STEP_MIN   = 5'd1;
    localparam logic [4:0]  STEP_MAX   = 5'd16;
    localparam logic [4:0]  STEP_RESET = 5'd1;
    localparam logic [4:0]  ODD_SINGLE = 5'd1;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV_STEP,
        F_DIV_RUN,
        F_PUSH
    } rmbp_front_state_t;

    typedef enum logic {
        B_IDLE,
        B_EMIT
    } rmbp_back_state_t;

    // Classified radial: everything the back end needs to emit its words
    typedef struct packed {
        logic [4:0]  corr;
        logic [5:0]  runs;
        logic        tail;
        logic [15:0] tail_word;
        logic [5:0]  count;
    } rmbp_desc_t;

    // Final word for a leftover of stepped bins
    function automatic logic [15:0] run_table_word(input logic [4:0] idx);
        logic [15:0] w;
        case (idx)
            5'd0:    w = 16'h0000;
            5'd1:    w = 16'h1000;
            5'd2:    w = 16'h1010;
            5'd3:    w = 16'h2010;
            5'd4:    w = 16'h3010;
            5'd5:    w = 16'h4010;
            5'd6:    w = 16'h5010;
            5'd7:    w = 16'h6010;
            5'd8:    w = 16'h7010;
            5'd9:    w = 16'h8010;
            5'd10:   w = 16'h9010;
            5'd11:   w = 16'hA010;
            5'd12:   w = 16'hB010;
            5'd13:   w = 16'hC010;
            5'd14:   w = 16'hD010;
            5'd15:   w = 16'hE010;
            5'd16:   w = 16'hF010;
            5'd17:   w = 16'hF020;
            5'd18:   w = 16'hF030;
            5'd19:   w = 16'hF040;
            5'd20:   w = 16'hF050;
            5'd21:   w = 16'hF060;
            5'd22:   w = 16'hF070;
            5'd23:   w = 16'hF080;
            5'd24:   w = 16'hF090;
            5'd25:   w = 16'hF0A0;
            5'd26:   w = 16'hF0B0;
            5'd27:   w = 16'hF0C0;
            5'd28:   w = 16'hF0D0;
            5'd29:   w = 16'hF0E0;
            default: w = 16'h0000;
        endcase
        return w;
    endfunction

endpackage

// File: hdl/rmbp_front.sv
// Front end: accepts radials, divides the missing-bin count by the bin step and by 30,
// reduces the base address modulo the buffer size, and pushes a descriptor.
// Depends on rmbp_pkg.
module rmbp_front #(
    parameter int MAX_BINS  = 1024,
    parameter int BUF_WORDS = 4096
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [4:0]                     cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [10:0]                    s_first_good_bin,
    input  logic [11:0]                    s_base_address,
    output logic                           push_valid,
    input  logic                           push_ready,
    output rmbp_pkg::rmbp_desc_t           push_desc,
    output logic [$clog2(BUF_WORDS)-1:0]   push_addr
);
    import rmbp_pkg::*;

    localparam int AW        = $clog2(BUF_WORDS);
    // Reciprocal of the buffer size, exact for every 12-bit base address
    localparam int BSH       = 12 + AW;
    localparam int BUF_RECIP = ((1 << BSH) + BUF_WORDS - 1) / BUF_WORDS;

    rmbp_front_state_t state_reg, state_next;
    logic [4:0]        bin_step_reg;
    logic [4:0]        step_reg, step_next;
    logic [4:0]        div_reg, div_next;
    logic [11:0]       num_reg, num_next;
    logic [4:0]        rem_reg, rem_next;
    logic [11:0]       base_reg, base_next;
    logic [AW-1:0]     brem_reg, brem_next;
    logic [11:0]       quo_reg, quo_next;
    logic [4:0]        corr_reg, corr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic [10:0] first_sat;
    logic [10:0] missing;
    logic [4:0]  step_eff;
    logic        last_iter;
    logic        run_last;
    logic [5:0]  rem_shift;
    logic        rem_ge;
    logic [4:0]  rem_new;
    logic [11:0] num_new;
    logic [25:0] bprod;
    logic [11:0] bquo;
    logic [AW-1:0] brem_new;
    logic [23:0] rprod;
    logic [11:0] rquo;
    logic [4:0]  odd_new;
    logic [12:0] words_raw;
    logic        tail;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_step_reg <= STEP_RESET;
        end else if (cfg_wr_en) begin
            bin_step_reg <= cfg_wr_data;
        end
    end

    // Clamp the inputs of the division
    always_comb begin
        first_sat = (s_first_good_bin > 11'(MAX_BINS)) ? 11'(MAX_BINS) : s_first_good_bin;
        missing   = (first_sat > 11'd1) ? 11'(first_sat - 11'd1) : 11'd0;
        if (bin_step_reg == 5'd0) begin
            step_eff = STEP_MIN;
        end else if (bin_step_reg > STEP_MAX) begin
            step_eff = STEP_MAX;
        end else begin
            step_eff = bin_step_reg;
        end
    end

    // One restoring step of the division by the bin step
    always_comb begin
        last_iter = (cnt_reg == CNT_W'(DIV_STEPS - 1));
        run_last  = (cnt_reg == CNT_W'(1));
        rem_shift = {rem_reg, num_reg[11]};
        rem_ge    = (rem_shift >= {1'b0, div_reg});
        rem_new   = rem_ge ? 5'(rem_shift - {1'b0, div_reg}) : rem_shift[4:0];
        num_new   = {num_reg[10:0], rem_ge};
    end

    // Reciprocal products: base over the buffer size, stepped bins over 30
    always_comb begin
        bprod    = 26'(base_reg) * 26'(BUF_RECIP);
        bquo     = 12'(bprod >> BSH);
        brem_new = AW'(base_reg - 12'(int'(quo_reg) * BUF_WORDS));
        rprod    = 24'(num_reg) * 24'(RUN_RECIP);
        rquo     = 12'(rprod >> RUN_SHIFT);
        odd_new  = 5'(num_reg - 12'(quo_reg * 12'(RUN_BINS)));
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (s_valid) state_next = F_DIV_STEP;
            end
            F_DIV_STEP: begin
                if (last_iter) state_next = F_DIV_RUN;
            end
            F_DIV_RUN: begin
                if (run_last) state_next = F_PUSH;
            end
            F_PUSH: begin
                if (push_ready) state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    // Datapath updates
    always_comb begin
        step_next = step_reg;
        div_next  = div_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        base_next = base_reg;
        brem_next = brem_reg;
        quo_next  = quo_reg;
        corr_next = corr_reg;
        cnt_next  = cnt_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (s_valid) begin
                    num_next  = {1'b0, missing};
                    rem_next  = '0;
                    div_next  = step_eff;
                    step_next = step_eff;
                    base_next = s_base_address;
                    brem_next = '0;
                    cnt_next  = '0;
                end
            end
            F_DIV_STEP: begin
                num_next = num_new;
                rem_next = rem_new;
                cnt_next = last_iter ? '0 : CNT_W'(cnt_reg + 1'b1);
                // Reduce the base address: quotient first, then the remainder
                if (cnt_reg == '0) begin
                    quo_next = bquo;
                end
                if (run_last) begin
                    brem_next = brem_new;
                end
                if (last_iter) begin
                    // Remainder is the start correction
                    corr_next = rem_new;
                end
            end
            F_DIV_RUN: begin
                cnt_next = run_last ? '0 : CNT_W'(cnt_reg + 1'b1);
                // Quotient by 30 first, then runs and leftover
                if (run_last) begin
                    num_next = quo_reg;
                    rem_next = odd_new;
                end else begin
                    quo_next = rquo;
                end
            end
            F_PUSH: begin
            end
            default: begin
            end
        endcase
    end

    // Outputs: classify the leftover and cap the word count
    always_comb begin
        s_ready    = (state_reg == F_IDLE);
        push_valid = (state_reg == F_PUSH);
        tail       = (rem_reg > ODD_SINGLE);
        words_raw  = {1'b0, num_reg} + 13'(tail);
        push_desc.tail      = tail;
        push_desc.tail_word = run_table_word(rem_reg);
        push_desc.corr      = (rem_reg == ODD_SINGLE) ? 5'(corr_reg + step_reg) : corr_reg;
        if (words_raw > 13'(MAX_WORDS)) begin
            push_desc.runs = 6'(MAX_WORDS - 6'(tail));
        end else begin
            push_desc.runs = num_reg[5:0];
        end
        push_desc.count = 6'(push_desc.runs + 6'(tail));
        push_addr       = brem_reg;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        div_reg  <= div_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        base_reg <= base_next;
        brem_reg <= brem_next;
        quo_reg  <= quo_next;
        corr_reg <= corr_next;
    end

endmodule

// File: hdl/rmbp_queue.sv
// Two-entry descriptor queue between the front and back ends.
// Depends on rmbp_pkg for its depth.
module rmbp_queue #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);
    import rmbp_pkg::*;

    logic [W-1:0]       entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QFILL_W-1:0] fill_reg, fill_next;
    logic               push;
    logic               pop;

    // Handshake and pointer updates
    always_comb begin
        in_ready    = (fill_reg != QFILL_W'(QUEUE_DEPTH));
        out_valid   = (fill_reg != '0);
        out_data    = entry_reg[rd_ptr_reg];
        push        = in_valid && in_ready;
        pop         = out_valid && out_ready;
        wr_ptr_next = push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        fill_next   = QFILL_W'(fill_reg + QFILL_W'(push) - QFILL_W'(pop));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// File: hdl/rmbp_back.sv
// Back end: expands one descriptor into its pad words, one beat per cycle while the
// receiver keeps taking them, through a registered output stage. Depends on rmbp_pkg.
module rmbp_back #(
    parameter int BUF_WORDS = 4096
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         desc_valid,
    output logic                         desc_ready,
    input  rmbp_pkg::rmbp_desc_t         desc,
    input  logic [$clog2(BUF_WORDS)-1:0] desc_addr,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_word_valid,
    output logic [15:0]                  m_pad_word,
    output logic [11:0]                  m_word_address,
    output logic [4:0]                   m_start_correction,
    output logic [5:0]                   m_word_count,
    output logic                         m_last_result
);
    import rmbp_pkg::*;

    localparam int AW = $clog2(BUF_WORDS);

    rmbp_back_state_t state_reg, state_next;
    rmbp_desc_t       desc_reg, desc_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [5:0]       idx_reg, idx_next;

    logic        m_valid_reg, m_valid_next;
    logic        word_valid_reg;
    logic [15:0] pad_word_reg;
    logic [11:0] word_address_reg;
    logic [4:0]  corr_out_reg;
    logic [5:0]  count_out_reg;
    logic        last_out_reg;

    logic        slot_free;
    logic        emit;
    logic        summary;
    logic        res_last;
    logic [15:0] res_word;

    // Current result
    always_comb begin
        slot_free = !m_valid_reg || m_ready;
        emit      = (state_reg == B_EMIT) && slot_free;
        summary   = (desc_reg.count == '0);
        res_last  = summary || (6'(idx_reg + 1'b1) == desc_reg.count);
        if (summary) begin
            res_word = '0;
        end else if (idx_reg < desc_reg.runs) begin
            res_word = RUN_WORD;
        end else begin
            res_word = desc_reg.tail_word;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (desc_valid) state_next = B_EMIT;
            end
            B_EMIT: begin
                if (emit && res_last) state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Outputs and working registers
    always_comb begin
        desc_ready   = (state_reg == B_IDLE);
        desc_next    = desc_reg;
        addr_next    = addr_reg;
        idx_next     = idx_reg;
        m_valid_next = slot_free ? emit : m_valid_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (desc_valid) begin
                    desc_next = desc;
                    addr_next = desc_addr;
                    idx_next  = '0;
                end
            end
            B_EMIT: begin
                if (emit) begin
                    idx_next  = 6'(idx_reg + 1'b1);
                    addr_next = (addr_reg == AW'(BUF_WORDS - 1)) ? '0 : AW'(addr_reg + 1'b1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold working payload; load output stage on each emitted beat
    always_ff @(posedge aclk) begin
        desc_reg <= desc_next;
        addr_reg <= addr_next;
        idx_reg  <= idx_next;
        if (emit) begin
            word_valid_reg   <= !summary;
            pad_word_reg     <= res_word;
            word_address_reg <= 12'(addr_reg);
            corr_out_reg     <= desc_reg.corr;
            count_out_reg    <= desc_reg.count;
            last_out_reg     <= res_last;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_word_valid       = word_valid_reg;
    assign m_pad_word         = pad_word_reg;
    assign m_word_address     = word_address_reg;
    assign m_start_correction = corr_out_reg;
    assign m_word_count       = count_out_reg;
    assign m_last_result      = last_out_reg;

    // A summary-only beat closes its radial and reports no words
    a_summary_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !word_valid_reg |-> last_out_reg && (count_out_reg == '0))
        else $error("summary beat not final or has nonzero word count");

    // Every beat before the last of a radial is a full run word
    a_runs_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !last_out_reg |-> word_valid_reg && (pad_word_reg == RUN_WORD))
        else $error("non-final beat is not a run word");

    // The emit index never runs past the word count
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_EMIT) && (desc_reg.count != '0) |-> idx_reg < desc_reg.count)
        else $error("emit index overran word count");

    // Word count stays within the cap
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> count_out_reg <= MAX_WORDS)
        else $error("word count above cap");

endmodule

// File: hdl/radial_missing_bin_pad_encoder.sv
// Radial missing-bin pad encoder, top level.
// Channels: s_* takes one radial per beat (first good bin, base address); m_* returns
//   the pad words of that radial, one beat each, in address order, the final beat
//   flagged by m_last_result. A radial with no words returns one summary beat with
//   m_word_valid low. cfg_wr_en/cfg_wr_data write the bin step; write only when idle.
// Flow: the front end divides by the bin step with its one-bit-per-cycle restoring
//   divider, splits the stepped count by 30 and pushes the descriptor; the back end
//   loads the descriptor and registers the first beat before m_valid rises.
// The front end takes no new radial until it has pushed the last one; the back end
//   loads each descriptor while idle, then emits one beat per cycle while the receiver
//   takes them.
// A two-entry descriptor queue separates the two ends, so the front keeps dividing
//   while the back waits on a stalled receiver; m_* beats hold in the output register
//   until taken. Synchronous reset (aresetn low) empties the queue and the output,
//   returns both ends to idle and sets the bin step to 1.
// Depends on rmbp_pkg, rmbp_front, rmbp_queue and rmbp_back.
module radial_missing_bin_pad_encoder #(
    parameter int MAX_BINS  = 1024,
    parameter int BUF_WORDS = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [10:0] s_first_good_bin,
    input  logic [11:0] s_base_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_word_valid,
    output logic [15:0] m_pad_word,
    output logic [11:0] m_word_address,
    output logic [4:0]  m_start_correction,
    output logic [5:0]  m_word_count,
    output logic        m_last_result
);
    import rmbp_pkg::*;

    localparam int AW = $clog2(BUF_WORDS);
    localparam int QW = $bits(rmbp_desc_t) + AW;

    logic          push_valid;
    logic          push_ready;
    rmbp_desc_t    push_desc;
    logic [AW-1:0] push_addr;
    logic          pop_valid;
    logic          pop_ready;
    rmbp_desc_t    pop_desc;
    logic [AW-1:0] pop_addr;
    logic [QW-1:0] q_in;
    logic [QW-1:0] q_out;

    assign q_in                 = {push_desc, push_addr};
    assign {pop_desc, pop_addr} = q_out;

    rmbp_front #(
        .MAX_BINS  (MAX_BINS),
        .BUF_WORDS (BUF_WORDS)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_first_good_bin (s_first_good_bin),
        .s_base_address   (s_base_address),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_desc        (push_desc),
        .push_addr        (push_addr)
    );

    rmbp_queue #(
        .W (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (q_in),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_data  (q_out)
    );

    rmbp_back #(
        .BUF_WORDS (BUF_WORDS)
    ) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .desc_valid         (pop_valid),
        .desc_ready         (pop_ready),
        .desc               (pop_desc),
        .desc_addr          (pop_addr),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_word_valid       (m_word_valid),
        .m_pad_word         (m_pad_word),
        .m_word_address     (m_word_address),
        .m_start_correction (m_start_correction),
        .m_word_count       (m_word_count),
        .m_last_result      (m_last_result)
    );

endmodule
